>>> hdl/mau_pkg.sv
// ============================================================================
// mau_pkg
// Types and constants shared by the modular arithmetic unit modules.
// ============================================================================
`default_nettype none

package mau_pkg;

    localparam int unsigned VW = 31;
    localparam int unsigned EW = 63;
    localparam int unsigned RW = 64;
    localparam int unsigned CW = 7;
    localparam logic [VW-1:0] MOD_RESET = 31'd998244353;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_NEG = 4'd4,
        OP_POW = 4'd5,
        OP_INV = 4'd6,
        OP_INC = 4'd7,
        OP_DEC = 4'd8,
        OP_RED = 4'd9
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETUP,
        ST_LOOP,
        ST_RSTART,
        ST_RSTEP,
        ST_COMMIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [3:0]         operation;
        logic [VW-1:0]      a_value;
        logic [VW-1:0]      b_value;
        logic [EW-1:0]      exponent;
        logic signed [RW-1:0] raw_value;
    } t_in;

    typedef struct packed {
        logic [VW-1:0] result;
        logic          a_less;
        logic          a_equal;
    } t_out;

    typedef struct packed {
        logic load;
        logic red_step;
        logic setup;
        logic div2;
        logic rnd_start;
        logic rnd_step;
        logic rnd_commit;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic m_bad;
        logic e_zero;
    } t_sts;

    // One bit of an interleaved modular multiply: (2r + bit*x) mod m, r,x < m.
    function automatic logic [VW-1:0] mul_step(input logic [VW-1:0] r,
                                               input logic [VW-1:0] x,
                                               input logic          bit_in,
                                               input logic [VW-1:0] m);
        logic [VW+1:0] t;
        logic [VW+1:0] m1;
        logic [VW+1:0] m2;
        logic [VW+1:0] d;
        t  = {1'b0, r, 1'b0} + (bit_in ? {2'b00, x} : '0);
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        if (t >= m2) begin
            d = t - m2;
        end else if (t >= m1) begin
            d = t - m1;
        end else begin
            d = t;
        end
        return d[VW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/mau_ctrl.sv
// ============================================================================
// mau_ctrl
// Sequencer: operand reduction, square-and-multiply rounds, result strobe.
// ============================================================================
`default_nettype none

module mau_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  mau_pkg::t_sts  i_sts,
    output mau_pkg::t_cmd  o_cmd
);

    localparam logic [mau_pkg::CW-1:0] LAST_V = mau_pkg::CW'(mau_pkg::VW - 1);
    localparam logic [mau_pkg::CW-1:0] LAST_R = mau_pkg::CW'(mau_pkg::RW - 1);

    mau_pkg::t_state             r_state, n_state;
    logic [mau_pkg::CW-1:0]      r_cnt, n_cnt;
    logic                        r_phase, n_phase;
    logic [mau_pkg::CW-1:0]      red_last;

    assign red_last = (i_sts.op == mau_pkg::OP_RED) ? LAST_R : LAST_V;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mau_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        o_cmd   = '0;
        busy    = (r_state != mau_pkg::ST_IDLE);
        case (r_state)
            mau_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_phase    = 1'b0;
                    n_state    = mau_pkg::ST_REDUCE;
                end
            end
            mau_pkg::ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == red_last) begin
                    n_state = mau_pkg::ST_SETUP;
                end
            end
            mau_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = mau_pkg::ST_LOOP;
            end
            mau_pkg::ST_LOOP: begin
                if (i_sts.m_bad) begin
                    n_state = mau_pkg::ST_FIN;
                end else if (i_sts.e_zero) begin
                    if (i_sts.op == mau_pkg::OP_DIV && !r_phase) begin
                        o_cmd.div2 = 1'b1;
                        n_phase    = 1'b1;
                    end else begin
                        n_state = mau_pkg::ST_FIN;
                    end
                end else begin
                    n_state = mau_pkg::ST_RSTART;
                end
            end
            mau_pkg::ST_RSTART: begin
                o_cmd.rnd_start = 1'b1;
                n_cnt           = '0;
                n_state         = mau_pkg::ST_RSTEP;
            end
            mau_pkg::ST_RSTEP: begin
                o_cmd.rnd_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_V) begin
                    n_state = mau_pkg::ST_COMMIT;
                end
            end
            mau_pkg::ST_COMMIT: begin
                o_cmd.rnd_commit = 1'b1;
                n_state          = mau_pkg::ST_LOOP;
            end
            mau_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = mau_pkg::ST_IDLE;
            end
            default: begin
                n_state = mau_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/mau_dpath.sv
// ============================================================================
// mau_dpath
// Operand registers, serial reducers, two modular multiply lanes, result.
// ============================================================================
`default_nettype none

module mau_dpath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mau_pkg::t_cmd                i_cmd,
    input  mau_pkg::t_in                 i_in,
    input  wire                          i_mod_we,
    input  wire [mau_pkg::VW-1:0]        i_mod_data,
    output mau_pkg::t_sts                o_sts,
    output mau_pkg::t_out                o_out,
    output logic                         o_valid
);

    localparam int unsigned VW = mau_pkg::VW;
    localparam int unsigned EW = mau_pkg::EW;
    localparam int unsigned RW = mau_pkg::RW;

    logic [VW-1:0]  r_mod;
    mau_pkg::t_op   r_op;
    logic [RW-1:0]  r_sh0;
    logic [VW-1:0]  r_sh1;
    logic [VW-1:0]  r_rda, r_rdb;
    logic           r_neg, r_less, r_equal;
    logic [EW-1:0]  r_ex, r_e;
    logic [VW-1:0]  r_acc, r_sq, r_ys, r_p0, r_p1;
    mau_pkg::t_out  r_out;
    logic           r_valid;

    logic [RW-1:0]  mag;
    logic [VW:0]    t0, t1;
    logic [VW-1:0]  n_rda, n_rdb;
    logic [VW-1:0]  res;
    logic [VW:0]    sum, dif;
    logic [VW-1:0]  one;

    assign one = VW'(1);
    assign mag = i_in.raw_value[RW-1] ? (~i_in.raw_value + 1'b1) : i_in.raw_value;

    assign t0    = {r_rda, r_sh0[RW-1]};
    assign t1    = {r_rdb, r_sh1[VW-1]};
    assign n_rda = (t0 >= {1'b0, r_mod}) ? VW'(t0 - {1'b0, r_mod}) : t0[VW-1:0];
    assign n_rdb = (t1 >= {1'b0, r_mod}) ? VW'(t1 - {1'b0, r_mod}) : t1[VW-1:0];

    assign sum = {1'b0, r_rda} + {1'b0, r_rdb};
    assign dif = {1'b0, r_rda} - {1'b0, r_rdb};

    always_comb begin
        res = '0;
        case (r_op)
            mau_pkg::OP_ADD: res = (sum >= {1'b0, r_mod}) ? VW'(sum - {1'b0, r_mod})
                                                          : sum[VW-1:0];
            mau_pkg::OP_SUB: res = dif[VW] ? VW'(dif + {1'b0, r_mod}) : dif[VW-1:0];
            mau_pkg::OP_MUL: res = r_acc;
            mau_pkg::OP_DIV: res = (r_rdb == '0) ? '0 : r_acc;
            mau_pkg::OP_NEG: res = (r_rda == '0) ? '0 : r_mod - r_rda;
            mau_pkg::OP_POW: res = r_acc;
            mau_pkg::OP_INV: res = (r_rda == '0) ? '0 : r_acc;
            mau_pkg::OP_INC: res = (r_rda == r_mod - one) ? '0 : r_rda + one;
            mau_pkg::OP_DEC: res = (r_rda == '0) ? r_mod - one : r_rda - one;
            mau_pkg::OP_RED: res = (r_neg && r_rda != '0) ? r_mod - r_rda : r_rda;
            default:         res = '0;
        endcase
        if (o_sts.m_bad) begin
            res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= mau_pkg::MOD_RESET;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fin;
            if (i_mod_we) begin
                r_mod <= i_mod_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= mau_pkg::t_op'(i_in.operation);
            r_sh0   <= (i_in.operation == mau_pkg::OP_RED) ? mag
                       : {i_in.a_value, (RW-VW)'(0)};
            r_sh1   <= i_in.b_value;
            r_rda   <= '0;
            r_rdb   <= '0;
            r_neg   <= i_in.raw_value[RW-1];
            r_ex    <= i_in.exponent;
            r_less  <= (i_in.a_value < i_in.b_value);
            r_equal <= (i_in.a_value == i_in.b_value);
        end
        if (i_cmd.red_step) begin
            r_rda <= n_rda;
            r_rdb <= n_rdb;
            r_sh0 <= {r_sh0[RW-2:0], 1'b0};
            r_sh1 <= {r_sh1[VW-2:0], 1'b0};
        end
        if (i_cmd.setup) begin
            case (r_op)
                mau_pkg::OP_MUL: begin
                    r_acc <= r_rda;
                    r_sq  <= r_rdb;
                    r_e   <= EW'(1);
                end
                mau_pkg::OP_POW: begin
                    r_acc <= one;
                    r_sq  <= r_rda;
                    r_e   <= r_ex;
                end
                mau_pkg::OP_INV: begin
                    r_acc <= one;
                    r_sq  <= r_rda;
                    r_e   <= EW'(r_mod - VW'(2));
                end
                mau_pkg::OP_DIV: begin
                    r_acc <= one;
                    r_sq  <= r_rdb;
                    r_e   <= EW'(r_mod - VW'(2));
                end
                default: begin
                    r_acc <= one;
                    r_sq  <= r_rda;
                    r_e   <= '0;
                end
            endcase
        end
        if (i_cmd.div2) begin
            r_sq <= r_rda;
            r_e  <= EW'(1);
        end
        if (i_cmd.rnd_start) begin
            r_p0 <= '0;
            r_p1 <= '0;
            r_ys <= r_sq;
        end
        if (i_cmd.rnd_step) begin
            r_p0 <= mau_pkg::mul_step(r_p0, r_acc, r_ys[VW-1], r_mod);
            r_p1 <= mau_pkg::mul_step(r_p1, r_sq, r_ys[VW-1], r_mod);
            r_ys <= {r_ys[VW-2:0], 1'b0};
        end
        if (i_cmd.rnd_commit) begin
            if (r_e[0]) begin
                r_acc <= r_p0;
            end
            r_sq <= r_p1;
            r_e  <= {1'b0, r_e[EW-1:1]};
        end
        if (i_cmd.fin) begin
            r_out.result  <= res;
            r_out.a_less  <= r_less;
            r_out.a_equal <= r_equal;
        end
    end

    assign o_sts.op     = r_op;
    assign o_sts.m_bad  = (r_mod < VW'(2));
    assign o_sts.e_zero = (r_e == '0);
    assign o_out        = r_out;
    assign o_valid      = r_valid;

endmodule

`default_nettype wire

>>> hdl/modular_arithmetic_unit.sv
// ============================================================================
// modular_arithmetic_unit
// Modular ALU over a writable modulus: add, sub, mul, div, neg, pow, inv,
// inc, dec and signed 64-bit reduce, with a_value/b_value compare flags.
//
//   channel   signals                          transfer
//   command   start, busy, i_cmd               start && !busy
//   result    o_result_valid, o_result         o_result_valid (one cycle)
//   config    i_cfg_valid, o_cfg_ready, data   i_cfg_valid && o_cfg_ready
//
// One transaction at a time. Operand reduction is bit-serial over the 31-bit
// operands (the 64-bit raw value for reduce); each square-and-multiply round
// runs on two bit-serial modular multiply lanes, and the pow exponent has
// 63 bits. Reset restores the modulus to 998244353.
// The result strobe cannot be held.
// ============================================================================
`default_nettype none

module modular_arithmetic_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  mau_pkg::t_in               i_cmd,
    output logic                       o_result_valid,
    output mau_pkg::t_out              o_result,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [mau_pkg::VW-1:0]      i_cfg_data
);

    mau_pkg::t_cmd cmd;
    mau_pkg::t_sts sts;

    assign o_cfg_ready = !busy;

    mau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mau_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in       (i_cmd),
        .i_mod_we   (i_cfg_valid && o_cfg_ready),
        .i_mod_data (i_cfg_data),
        .o_sts      (sts),
        .o_out      (o_result),
        .o_valid    (o_result_valid)
    );

`ifndef SYNTH
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

>>> bench/mau_checker.sv
// ============================================================================
// mau_checker
// Watches the command, result and modulus channels of the modular arithmetic
// unit. Predicts each result from the accepted command and the modulus copy
// held here, then compares it field by field with the strobed result.
// ============================================================================
`default_nettype none

module mau_checker
    import mau_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire           i_busy,
    input  t_in           i_cmd,
    input  wire           i_result_valid,
    input  t_out          i_result,
    input  wire           i_cfg_valid,
    input  wire           i_cfg_ready,
    input  wire [VW-1:0]  i_cfg_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_commands,
    output int            o_results,
    output int            o_mod_writes
);

    logic [VW-1:0] modulus_q;
    t_out          result_fifo[$];

    function automatic longint unsigned pow_mod(longint unsigned base,
                                                longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % m;
        sq  = base % m;
        for (int i = 0; i < 64; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc;
    endfunction

    function automatic longint unsigned inv_mod(longint unsigned x, longint unsigned m);
        if (x == 0) begin
            return 0;
        end
        return pow_mod(x, m - 2, m);
    endfunction

    function automatic t_out predict_result(t_in c, logic [VW-1:0] mod_val);
        t_out            r;
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned v;
        longint unsigned mag;
        m = mod_val;
        v = 0;
        if (m >= 2) begin
            a = c.a_value % m;
            b = c.b_value % m;
            case (c.operation)
                OP_ADD: v = (a + b >= m) ? a + b - m : a + b;
                OP_SUB: v = (a < b) ? m - b + a : a - b;
                OP_MUL: v = (a * b) % m;
                OP_DIV: v = (a * inv_mod(b, m)) % m;
                OP_NEG: v = (a != 0) ? m - a : 0;
                OP_POW: v = pow_mod(a, {1'b0, c.exponent}, m);
                OP_INV: v = inv_mod(a, m);
                OP_INC: v = (a == m - 1) ? 0 : a + 1;
                OP_DEC: v = (a != 0) ? a - 1 : m - 1;
                OP_RED: begin
                    if (c.raw_value[RW-1]) begin
                        mag = 64'd0 - c.raw_value;
                        v   = mag % m;
                        v   = (v != 0) ? m - v : 0;
                    end else begin
                        v = c.raw_value % m;
                    end
                end
                default: v = 0;
            endcase
        end
        r.result  = v[VW-1:0];
        r.a_less  = c.a_value < c.b_value;
        r.a_equal = c.a_value == c.b_value;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            modulus_q = MOD_RESET;
            result_fifo.delete();
            o_commands   <= 0;
            o_results    <= 0;
            o_mod_writes <= 0;
        end else begin
            if (i_result_valid) begin
                if (result_fifo.size() == 0) begin
                    report_mismatch("unexpected result", i_result.result, 0);
                end else begin
                    want = result_fifo.pop_front();
                    if (i_result.result !== want.result)
                        report_mismatch("result", i_result.result, want.result);
                    if (i_result.a_less !== want.a_less)
                        report_mismatch("a_less", i_result.a_less, want.a_less);
                    if (i_result.a_equal !== want.a_equal)
                        report_mismatch("a_equal", i_result.a_equal, want.a_equal);
                end
                o_results <= o_results + 1;
            end
            if (i_start && !i_busy) begin
                result_fifo.push_back(predict_result(i_cmd, modulus_q));
                o_commands <= o_commands + 1;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                modulus_q = i_cfg_data;
                o_mod_writes <= o_mod_writes + 1;
            end
        end
        o_pending <= result_fifo.size();
    end

endmodule

`default_nettype wire

>>> bench/tb_modular_arithmetic_unit.sv
// ============================================================================
// tb_modular_arithmetic_unit
// Drives directed commands under the reset modulus, then random commands
// under a series of modulus values, including the bounds and the degenerate
// values 0 and 1. A checker beside the block predicts and compares results.
// ============================================================================
`default_nettype none

module tb_modular_arithmetic_unit;
    import mau_pkg::*;

    localparam logic [3:0] OP_SPARE_LO = 4'd10;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam int         STALL_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_in           cmd;
    logic          result_valid;
    t_out          result;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [VW-1:0] cfg_data;

    int            errors;
    int            pending;
    int            commands;
    int            results;
    int            mod_writes;
    int            stall_cycles;
    int            sent;
    logic [VW-1:0] cur_mod;

    modular_arithmetic_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (cmd),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    mau_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (cmd),
        .i_result_valid (result_valid),
        .i_result       (result),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_commands     (commands),
        .o_results      (results),
        .o_mod_writes   (mod_writes)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_modular_arithmetic_unit failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in make_cmd(logic [3:0] op, logic [VW-1:0] a, logic [VW-1:0] b,
                                     logic [EW-1:0] e, logic [RW-1:0] raw);
        t_in c;
        c.operation = op;
        c.a_value   = a;
        c.b_value   = b;
        c.exponent  = e;
        c.raw_value = raw;
        return c;
    endfunction

    function automatic logic [VW-1:0] rand_operand(logic [VW-1:0] m);
        if (m < 2 || $urandom_range(9, 0) == 0) begin
            return VW'($urandom);
        end
        return VW'($urandom_range(m - 1, 0));
    endfunction

    function automatic t_in rand_cmd(logic [VW-1:0] m);
        logic [3:0]    op;
        logic [EW-1:0] e;
        op = ($urandom_range(19, 0) == 0) ? 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))
                                          : 4'($urandom_range(OP_RED, OP_ADD));
        e  = EW'({$urandom, $urandom});
        e  = e >> $urandom_range(EW - 1, 0);
        return make_cmd(op, rand_operand(m), rand_operand(m), e, {$urandom, $urandom});
    endfunction

    task automatic send_cmd(t_in c);
        if (!(sent >= 700 && sent < 1000) && $urandom_range(99, 0) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_modulus(logic [VW-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cur_mod = v;
    endtask

    task automatic send_directed(logic [VW-1:0] m);
        send_cmd(make_cmd(OP_ADD, m - 1, m - 1, '0, '0));
        send_cmd(make_cmd(OP_SUB, 0, m - 1, '0, '0));
        send_cmd(make_cmd(OP_MUL, m - 1, m - 1, '0, '0));
        send_cmd(make_cmd(OP_DIV, 12345, 0, '0, '0));
        send_cmd(make_cmd(OP_DIV, m - 1, 7, '0, '0));
        send_cmd(make_cmd(OP_NEG, 0, 5, '0, '0));
        send_cmd(make_cmd(OP_NEG, m - 1, 5, '0, '0));
        send_cmd(make_cmd(OP_POW, 0, 0, '0, '0));
        send_cmd(make_cmd(OP_POW, m - 1, 3, '1, '0));
        send_cmd(make_cmd(OP_INV, 0, 0, '0, '0));
        send_cmd(make_cmd(OP_INV, 1, 2, '0, '0));
        send_cmd(make_cmd(OP_INV, m - 1, 0, '0, '0));
        send_cmd(make_cmd(OP_INC, m - 1, m - 1, '0, '0));
        send_cmd(make_cmd(OP_DEC, 0, 1, '0, '0));
        send_cmd(make_cmd(OP_RED, 3, 2, '0, {1'b1, {(RW-1){1'b0}}}));
        send_cmd(make_cmd(OP_RED, 3, 3, '0, {1'b0, {(RW-1){1'b1}}}));
        send_cmd(make_cmd(OP_RED, 0, 0, '0, '1));
        send_cmd(make_cmd(OP_ADD, '1, '1, '0, '0));
        send_cmd(make_cmd(OP_MUL, '1, {VW{1'b1}} - 1, '0, '0));
        send_cmd(make_cmd(OP_SPARE_LO, 4, 4, '1, '1));
        send_cmd(make_cmd(OP_SPARE_HI, '1, 0, '1, '1));
    endtask

    initial begin
        logic [VW-1:0] mod_list[8];
        int            mod_items[8];
        mod_list  = '{31'd2, 31'd2147483647, 31'd13, 31'd0, 31'd1, 31'd65537,
                      31'd1000000007, MOD_RESET};
        mod_items = '{150, 600, 200, 40, 40, 300, 450, 150};
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        stall_cycles = 0;
        sent      = 0;
        cur_mod   = MOD_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed(cur_mod);
        for (int p = 0; p < 8; p++) begin
            write_modulus(mod_list[p]);
            for (int n = 0; n < mod_items[p]; n++) begin
                if (p == 6 && n == 200) begin
                    drain();
                end
                send_cmd(rand_cmd(cur_mod));
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d commands, %0d results, %0d modulus writes", commands, results,
                 mod_writes);
        $display("moduli: 0, 1, 2, 13, 65537, 998244353, 1000000007, 2147483647");
        if (errors == 0 && pending == 0) begin
            $display("tb_modular_arithmetic_unit passed");
        end else begin
            $display("tb_modular_arithmetic_unit failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
